FILE: rtl/core/mebl_pkg.sv
// ----------------------------------------------------------------------------
// mebl_pkg
// Shared types and codes for the mask erosion and boundary labelling core.
// ----------------------------------------------------------------------------
package mebl_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 12;

   typedef enum logic [0:0] {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      LABEL_OUTSIDE  = 2'd0,
      LABEL_INTERIOR = 2'd1,
      LABEL_BOUNDARY = 2'd2
   } label_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH   = 3'd0,
      CSR_IMAGE_HEIGHT  = 3'd1,
      CSR_REGION_X      = 3'd2,
      CSR_REGION_Y      = 3'd3,
      CSR_REGION_WIDTH  = 3'd4,
      CSR_REGION_HEIGHT = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [0:0] operation;
      logic [7:0] alpha_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  label;
      logic [9:0]  row;
      logic [9:0]  column;
      logic        frame_end;
      logic [20:0] interior_count;
      logic [9:0]  box_x;
      logic [9:0]  box_y;
      logic [10:0] box_width;
      logic [10:0] box_height;
   } rsp_type;

   // one line-buffer word per column: mask of rows r-1 and r-2,
   // interior of rows r-2 and r-3
   typedef struct packed {
      logic mask_new;
      logic mask_old;
      logic int_new;
      logic int_old;
   } line_word_type;

endpackage

FILE: rtl/core/mask_erode_boundary_label_core.sv
// ----------------------------------------------------------------------------
// mask_erode_boundary_label_core
// Cross erosion of an alpha mask with interior / boundary-ring labelling.
// ----------------------------------------------------------------------------
// Takes one pixel or flush item per clock while req_stall is low. Each processed
// item reads one word and writes one word of a single line memory (MAX_WIDTH
// words of 4 bits, one read and one write port); the read for the next column
// is issued one item ahead, so the memory port sets the rate at one item per
// cycle. A result leaves through an output register, two rows behind the input;
// a skid stage keeps the input open while one result waits in that register.
// Stall is raised after reset and after each configuration write while the
// derived geometry registers settle. No clearing pass is needed: line entries
// read before their first write in a frame are gated by the row and region checks.
// ----------------------------------------------------------------------------
module mask_erode_boundary_label_core
   import mebl_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int AW  = $clog2(MAX_WIDTH);
   localparam int WB  = $clog2(MAX_WIDTH + 1);
   localparam int HB  = $clog2(MAX_HEIGHT + 1);
   localparam int RW  = $clog2(MAX_HEIGHT + 2);
   localparam int WHB = (WB > HB) ? WB : HB;
   localparam int DW  = ((WHB > 12) ? WHB : 12) + 2;
   localparam int NB  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

   // configuration registers
   logic [10:0] img_w_ff, img_h_ff, reg_x_ff, reg_y_ff;
   logic [11:0] reg_w_ff, reg_h_ff;
   logic        cfg_pend_ff;
   logic        csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff    <= 11'd1024;
         img_h_ff    <= 11'd1024;
         reg_x_ff    <= 11'd0;
         reg_y_ff    <= 11'd0;
         reg_w_ff    <= 12'd1024;
         reg_h_ff    <= 12'd1024;
         cfg_pend_ff <= 1'b1;
      end else begin
         cfg_pend_ff <= csr_wr;
         if (csr_wr) begin
            unique case (csr_index)
               CSR_IMAGE_WIDTH:   img_w_ff <= csr_data[10:0];
               CSR_IMAGE_HEIGHT:  img_h_ff <= csr_data[10:0];
               CSR_REGION_X:      reg_x_ff <= csr_data[10:0];
               CSR_REGION_Y:      reg_y_ff <= csr_data[10:0];
               CSR_REGION_WIDTH:  reg_w_ff <= csr_data;
               CSR_REGION_HEIGHT: reg_h_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // derived geometry
   logic signed [DW-1:0] w_raw, h_raw, w_eff, h_eff, rx, ry, ex, ey;
   logic signed [DW-1:0] l_in, r_in, t_in, b_in, wm1_c, hp1_c;
   logic signed [DW-1:0] geo_l_ff, geo_r_ff, geo_t_ff, geo_b_ff;
   logic [WB-1:0]        geo_w_ff;
   logic [AW-1:0]        geo_wm1_ff;
   logic [RW-1:0]        geo_h_ff, geo_hp1_ff;

   always_comb begin
      w_raw = DW'(img_w_ff);
      h_raw = DW'(img_h_ff);
      if (w_raw < DW'(3)) begin
         w_eff = DW'(3);
      end else if (w_raw > DW'(MAX_WIDTH)) begin
         w_eff = DW'(MAX_WIDTH);
      end else begin
         w_eff = w_raw;
      end
      if (h_raw < DW'(3)) begin
         h_eff = DW'(3);
      end else if (h_raw > DW'(MAX_HEIGHT)) begin
         h_eff = DW'(MAX_HEIGHT);
      end else begin
         h_eff = h_raw;
      end
      rx    = DW'($signed(reg_x_ff));
      ry    = DW'($signed(reg_y_ff));
      ex    = rx + DW'(reg_w_ff);
      ey    = ry + DW'(reg_h_ff);
      l_in  = ((rx > DW'(0)) ? rx : DW'(0)) + DW'(1);
      t_in  = ((ry > DW'(0)) ? ry : DW'(0)) + DW'(1);
      r_in  = ((ex < w_eff) ? ex : w_eff) - DW'(2);
      b_in  = ((ey < h_eff) ? ey : h_eff) - DW'(2);
      wm1_c = w_eff - DW'(1);
      hp1_c = h_eff + DW'(1);
   end

   always_ff @(posedge clock) begin
      geo_l_ff   <= l_in;
      geo_r_ff   <= r_in;
      geo_t_ff   <= t_in;
      geo_b_ff   <= b_in;
      geo_w_ff   <= w_eff[WB-1:0];
      geo_wm1_ff <= wm1_c[AW-1:0];
      geo_h_ff   <= h_eff[RW-1:0];
      geo_hp1_ff <= hp1_c[RW-1:0];
   end

   // frame position and item decode
   logic [AW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in, row_i, row_o;
   logic          accept, is_flush, pix_phase, proc, m;
   logic          col_first, col_last, row_ge1, row_ge2, row_ge3, last;

   assign accept    = req_valid & ~req_stall;
   assign is_flush  = (req_data.operation == OP_FLUSH);
   assign pix_phase = (row_ff < geo_h_ff);
   assign proc      = accept & (is_flush ? ~pix_phase : pix_phase);
   assign m         = ~is_flush & (req_data.alpha_value != 8'd0);
   assign col_first = (col_ff == '0);
   assign col_last  = (col_ff == geo_wm1_ff);
   assign row_i     = row_ff - RW'(1);
   assign row_o     = row_ff - RW'(2);
   assign row_ge1   = (row_ff != '0);
   assign row_ge2   = (row_ff >= RW'(2));
   assign row_ge3   = (row_ff >= RW'(3));
   assign last      = (row_ff == geo_hp1_ff) & col_last;

   // line memory and column window
   line_word_type line_mem [MAX_WIDTH];
   line_word_type rd_word_ff, cur_word_ff, left_word_ff, wr_word;
   logic [AW+1:0] c_p2, w_x, rd_full;
   logic [AW-1:0] rd_addr;

   assign c_p2    = {2'b00, col_ff} + (AW+2)'(2);
   assign w_x     = (AW+2)'(geo_w_ff);
   assign rd_full = (c_p2 >= w_x) ? (c_p2 - w_x) : c_p2;
   assign rd_addr = rd_full[AW-1:0];

   always_ff @(posedge clock) begin
      if (proc) begin
         line_mem[col_ff] <= wr_word;
         rd_word_ff       <= line_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (proc) begin
         left_word_ff <= cur_word_ff;
         cur_word_ff  <= rd_word_ff;
      end
   end

   // erosion and labelling
   logic signed [DW-1:0] i_s, c_s;
   logic                 in_region, inew, up_i, left_i, right_i, mid_i;
   logic [1:0]           label_c;

   assign i_s       = DW'(row_i);
   assign c_s       = DW'(col_ff);
   assign in_region = (i_s >= geo_t_ff) && (i_s <= geo_b_ff) &&
                      (c_s >= geo_l_ff) && (c_s <= geo_r_ff);
   assign inew      = row_ge1 & in_region & cur_word_ff.mask_new & cur_word_ff.mask_old &
                      left_word_ff.mask_new & rd_word_ff.mask_new & m;
   assign mid_i     = cur_word_ff.int_new;
   assign up_i      = row_ge3 & cur_word_ff.int_old;
   assign left_i    = ~col_first & left_word_ff.int_new;
   assign right_i   = ~col_last & rd_word_ff.int_new;
   assign label_c   = mid_i ? LABEL_INTERIOR :
                      ((up_i | inew | left_i | right_i) ? LABEL_BOUNDARY : LABEL_OUTSIDE);

   always_comb begin
      wr_word.mask_new = m;
      wr_word.mask_old = cur_word_ff.mask_new;
      wr_word.int_new  = inew;
      wr_word.int_old  = cur_word_ff.int_new;
   end

   // interior statistics
   logic [NB-1:0] count_ff, count_in, cnt_upd;
   logic [AW-1:0] min_col_ff, max_col_ff, min_col_in, max_col_in, min_col_upd, max_col_upd;
   logic [RW-1:0] min_row_ff, max_row_ff, min_row_in, max_row_in, min_row_upd, max_row_upd;
   logic          hit, frame_clear;

   assign hit         = proc & inew;
   assign frame_clear = csr_wr | (proc & last);

   always_comb begin
      cnt_upd     = count_ff + NB'(hit);
      min_col_upd = (hit && (col_ff < min_col_ff)) ? col_ff : min_col_ff;
      max_col_upd = (hit && (col_ff > max_col_ff)) ? col_ff : max_col_ff;
      min_row_upd = (hit && (row_i < min_row_ff)) ? row_i : min_row_ff;
      max_row_upd = (hit && (row_i > max_row_ff)) ? row_i : max_row_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      if (proc) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
      count_in   = cnt_upd;
      min_col_in = min_col_upd;
      max_col_in = max_col_upd;
      min_row_in = min_row_upd;
      max_row_in = max_row_upd;
      if (frame_clear) begin
         col_in     = '0;
         row_in     = '0;
         count_in   = '0;
         min_col_in = '1;
         max_col_in = '0;
         min_row_in = '1;
         max_row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         count_ff   <= '0;
         min_col_ff <= '1;
         max_col_ff <= '0;
         min_row_ff <= '1;
         max_row_ff <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         count_ff   <= count_in;
         min_col_ff <= min_col_in;
         max_col_ff <= max_col_in;
         min_row_ff <= min_row_in;
         max_row_ff <= max_row_in;
      end
   end

   // result assembly
   logic [AW+9:0]  col_ext;
   logic [RW+9:0]  row_ext;
   logic [NB+20:0] cnt_ext;
   logic [AW-1:0]  bx;
   logic [RW-1:0]  by;
   logic [AW+1:0]  bw;
   logic [RW+1:0]  bh;
   logic [AW+9:0]  bx_ext;
   logic [RW+9:0]  by_ext;
   logic [AW+12:0] bw_ext;
   logic [RW+12:0] bh_ext;
   logic           res_valid, summary;
   rsp_type        res;

   assign res_valid = proc & row_ge2;
   assign summary   = last & (cnt_upd != '0);
   assign col_ext   = {10'd0, col_ff};
   assign row_ext   = {10'd0, row_o};
   assign cnt_ext   = {21'd0, cnt_upd};
   assign bx        = min_col_upd - AW'(1);
   assign by        = min_row_upd - RW'(1);
   assign bw        = {2'b00, max_col_upd} - {2'b00, min_col_upd} + (AW+2)'(3);
   assign bh        = {2'b00, max_row_upd} - {2'b00, min_row_upd} + (RW+2)'(3);
   assign bx_ext    = {10'd0, bx};
   assign by_ext    = {10'd0, by};
   assign bw_ext    = {11'd0, bw};
   assign bh_ext    = {11'd0, bh};

   always_comb begin
      res.label          = label_c;
      res.row            = row_ext[9:0];
      res.column         = col_ext[9:0];
      res.frame_end      = last;
      res.interior_count = summary ? cnt_ext[20:0] : 21'd0;
      res.box_x          = summary ? bx_ext[9:0] : 10'd0;
      res.box_y          = summary ? by_ext[9:0] : 10'd0;
      res.box_width      = summary ? bw_ext[10:0] : 11'd0;
      res.box_height     = summary ? bh_ext[10:0] : 11'd0;
   end

   // output register with skid stage
   logic    rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in, out_take;
   rsp_type rsp_data_ff, rsp_data_in, skid_data_ff, skid_data_in;

   assign out_take = rsp_valid_ff & ~rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      priority if (skid_valid_ff) begin
         if (out_take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (~rsp_valid_ff | out_take) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = res;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = res;
         end
      end else if (out_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req_stall = skid_valid_ff | cfg_pend_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/core/mebl_checker.sv
// ----------------------------------------------------------------------------
// mebl_checker
// Port-level checks for the mask erosion and boundary labelling core.
// ----------------------------------------------------------------------------
module mebl_checker
   import mebl_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input req_type                   req_data,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input rsp_type                   rsp_data,
   input logic                      csr_valid,
   input logic                      csr_ready,
   input logic [CSR_INDEX_BITS-1:0] csr_index,
   input logic [CSR_DATA_BITS-1:0]  csr_data
);

   // stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_summary_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.frame_end |->
         rsp_data.interior_count == 21'd0 && rsp_data.box_x == 10'd0 &&
         rsp_data.box_y == 10'd0 && rsp_data.box_width == 11'd0 &&
         rsp_data.box_height == 11'd0)
      else $error("summary fields set away from frame end");

   // last pixel of a frame can never be interior nor touch one
   a_last_outside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_end |-> rsp_data.label == LABEL_OUTSIDE)
      else $error("frame end pixel labelled");

   a_empty_box: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_end && rsp_data.interior_count == 21'd0 |->
         rsp_data.box_width == 11'd0 && rsp_data.box_height == 11'd0)
      else $error("box reported without interior pixels");

   a_csr_settle: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> req_stall)
      else $error("input open before geometry settled");

endmodule

bind mask_erode_boundary_label_core mebl_checker u_mebl_checker (.*);
